/* hdl/cbts_pkg.sv */
// ----------------------------------------------------------------------------
// cbts_pkg
// Shared widths, register indexes and constants of the bit timing search.
// ----------------------------------------------------------------------------
package cbts_pkg;

    localparam int CLK_W  = 27;
    localparam int BAUD_W = 20;
    localparam int DIV_W  = 4;
    localparam int WORD_W = 15;
    localparam int IDX_W  = 1;

    localparam logic [IDX_W-1:0] REG_CLOCK_RATE  = 1'b0;
    localparam logic [IDX_W-1:0] REG_SAMPLE_MODE = 1'b1;

    localparam logic [CLK_W-1:0] CLOCK_RATE_RESET  = 27'd48000000;
    localparam logic             SAMPLE_MODE_RESET = 1'b1;

    localparam logic [BAUD_W-1:0] BAUD_HIGH = 20'd800000;
    localparam logic [BAUD_W-1:0] BAUD_MID  = 20'd500000;

    // Sample point percentage times 2^17/100, rounded up
    localparam int RECIP_SHIFT = 17;
    localparam logic [16:0] RECIP_75 = 17'(75 * 1311);
    localparam logic [16:0] RECIP_80 = 17'(80 * 1311);
    localparam logic [16:0] RECIP_87 = 17'(87 * 1311);

    localparam logic [4:0] SEGS_FIRST   = 5'd3;
    localparam logic [4:0] SEGS_LAST    = 5'd17;
    localparam logic [4:0] QUANTA_LAST  = 5'd31;
    localparam logic [3:0] DIV_LAST     = 4'd15;
    localparam logic [4:0] DIV_STEPS    = 5'd27;

endpackage

/* hdl/can_bit_timing_search_core.sv */
// ----------------------------------------------------------------------------
// can_bit_timing_search_core
// Divides the clock rate by the bit rate, then walks divider, quanta and
// segment counts until the product matches, and packs the timing word.
// ----------------------------------------------------------------------------
// Sequence: restoring division of the clock rate, then up to 7680 candidates
// checked in turn, then ST_FIN packs the word and raises done; a zero bit rate
// skips division and search. The next start is taken during done.
// done strobes the result for one cycle; the receiver cannot stall.
// Reset: idle, clock_rate 48000000, sample_point_mode 1, outputs zero.
module can_bit_timing_search_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [cbts_pkg::IDX_W-1:0]      cfg_index,
    input  logic [cbts_pkg::CLK_W-1:0]      cfg_data,
    input  logic                            start,
    input  logic [cbts_pkg::BAUD_W-1:0]     bit_rate,
    output logic                            busy,
    output logic                            done,
    output logic                            found,
    output logic [cbts_pkg::DIV_W-1:0]      clock_divider,
    output logic [cbts_pkg::WORD_W-1:0]     bit_timing_word
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DIV    = 2'd1;
    localparam logic [1:0] ST_SEARCH = 2'd2;
    localparam logic [1:0] ST_FIN    = 2'd3;

    logic [1:0]                    state_reg, state_next;
    logic [cbts_pkg::CLK_W-1:0]    clock_rate_reg;
    logic                          mode_reg;
    logic [cbts_pkg::BAUD_W-1:0]   baud_reg, baud_next;
    logic [cbts_pkg::BAUD_W:0]     rem_reg, rem_next;
    logic [cbts_pkg::CLK_W-1:0]    quot_reg, quot_next;
    logic [4:0]                    step_reg, step_next;
    logic [3:0]                    div_reg, div_next;
    logic [4:0]                    quanta_reg, quanta_next;
    logic [4:0]                    segs_reg, segs_next;
    logic [9:0]                    qd_reg, qd_next;
    logic [13:0]                   acc_reg, acc_next;
    logic                          hit_reg, hit_next;
    logic                          done_reg, done_next;
    logic                          found_reg, found_next;
    logic [cbts_pkg::DIV_W-1:0]    cdiv_reg, cdiv_next;
    logic [cbts_pkg::WORD_W-1:0]   word_reg, word_next;

    logic [cbts_pkg::BAUD_W:0]     rem_shift;
    logic [cbts_pkg::BAUD_W:0]     rem_sub;
    logic [9:0]                    qd_step;
    logic [9:0]                    div_plus;
    logic [13:0]                   acc_step;

    logic [3:0]                    r;
    logic [16:0]                   recip;
    logic [20:0]                   prod;
    logic [3:0]                    q;
    logic [4:0]                    t2_raw;
    logic [4:0]                    t2;
    logic [4:0]                    t1w;
    logic [1:0]                    sjw;

    function automatic logic [13:0] times3(input logic [9:0] x);
        times3 = {3'd0, x, 1'b0} + {4'd0, x};
    endfunction

    assign rem_shift = {rem_reg[cbts_pkg::BAUD_W-1:0], quot_reg[cbts_pkg::CLK_W-1]};
    assign rem_sub   = rem_shift - {1'b0, baud_reg};
    assign div_plus  = {6'd0, div_reg} + 10'd1;
    assign qd_step   = qd_reg + div_plus;
    assign acc_step  = acc_reg + {4'd0, qd_reg};

    always_comb
    begin
        r = segs_reg[3:0] - cbts_pkg::SEGS_FIRST[3:0];
        if (baud_reg > cbts_pkg::BAUD_HIGH)
        begin
            recip = cbts_pkg::RECIP_75;
        end
        else if (baud_reg > cbts_pkg::BAUD_MID)
        begin
            recip = cbts_pkg::RECIP_80;
        end
        else
        begin
            recip = cbts_pkg::RECIP_87;
        end
        prod   = {17'd0, r} * {4'd0, recip};
        q      = prod[cbts_pkg::RECIP_SHIFT +: 4];
        t2_raw = {1'b0, r} - {1'b0, q};
        if (!mode_reg)
        begin
            t1w = {2'b00, r[3:1]};
            t2  = {1'b0, r} - t1w;
        end
        else
        begin
            if (t2_raw == 5'd0)
            begin
                t2 = 5'd1;
            end
            else if (t2_raw > 5'd8)
            begin
                t2 = 5'd8;
            end
            else
            begin
                t2 = t2_raw;
            end
            t1w = {1'b0, r} - t2;
        end
        sjw = (t1w[4] || t1w[3:0] > 4'd3) ? 2'd3 : t1w[1:0];
    end

    always_comb
    begin
        state_next  = state_reg;
        baud_next   = baud_reg;
        rem_next    = rem_reg;
        quot_next   = quot_reg;
        step_next   = step_reg;
        div_next    = div_reg;
        quanta_next = quanta_reg;
        segs_next   = segs_reg;
        qd_next     = qd_reg;
        acc_next    = acc_reg;
        hit_next    = hit_reg;
        done_next   = 1'b0;
        found_next  = found_reg;
        cdiv_next   = cdiv_reg;
        word_next   = word_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    baud_next = bit_rate;
                    rem_next  = '0;
                    quot_next = clock_rate_reg;
                    step_next = '0;
                    hit_next  = 1'b0;
                    state_next = (bit_rate == '0) ? ST_FIN : ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!rem_sub[cbts_pkg::BAUD_W])
                begin
                    rem_next  = rem_sub;
                    quot_next = {quot_reg[cbts_pkg::CLK_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_shift;
                    quot_next = {quot_reg[cbts_pkg::CLK_W-2:0], 1'b0};
                end
                step_next = step_reg + 5'd1;
                if (step_reg == cbts_pkg::DIV_STEPS - 5'd1)
                begin
                    div_next    = '0;
                    quanta_next = '0;
                    segs_next   = cbts_pkg::SEGS_FIRST;
                    qd_next     = 10'd1;
                    acc_next    = 14'd3;
                    state_next  = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (quot_reg == {13'd0, acc_reg})
                begin
                    hit_next   = 1'b1;
                    state_next = ST_FIN;
                end
                else if (segs_reg != cbts_pkg::SEGS_LAST)
                begin
                    segs_next = segs_reg + 5'd1;
                    acc_next  = acc_step;
                end
                else
                begin
                    segs_next = cbts_pkg::SEGS_FIRST;
                    if (quanta_reg != cbts_pkg::QUANTA_LAST)
                    begin
                        quanta_next = quanta_reg + 5'd1;
                        qd_next     = qd_step;
                        acc_next    = times3(qd_step);
                    end
                    else
                    begin
                        quanta_next = '0;
                        if (div_reg != cbts_pkg::DIV_LAST)
                        begin
                            div_next = div_reg + 4'd1;
                            qd_next  = div_plus + 10'd1;
                            acc_next = times3(div_plus + 10'd1);
                        end
                        else
                        begin
                            state_next = ST_FIN;
                        end
                    end
                end
            end
            ST_FIN:
            begin
                done_next  = 1'b1;
                found_next = hit_reg;
                if (hit_reg)
                begin
                    cdiv_next = div_reg;
                    word_next = {t2[2:0], t1w[3:0], sjw, 1'b0, quanta_reg};
                end
                else
                begin
                    cdiv_next = '0;
                    word_next = '0;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            clock_rate_reg <= cbts_pkg::CLOCK_RATE_RESET;
            mode_reg       <= cbts_pkg::SAMPLE_MODE_RESET;
            hit_reg        <= 1'b0;
            done_reg       <= 1'b0;
            found_reg      <= 1'b0;
            cdiv_reg       <= '0;
            word_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            hit_reg   <= hit_next;
            done_reg  <= done_next;
            found_reg <= found_next;
            cdiv_reg  <= cdiv_next;
            word_reg  <= word_next;
            if (cfg_we)
            begin
                if (cfg_index == cbts_pkg::REG_CLOCK_RATE)
                begin
                    clock_rate_reg <= cfg_data;
                end
                else if (cfg_index == cbts_pkg::REG_SAMPLE_MODE)
                begin
                    mode_reg <= cfg_data[0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        baud_reg   <= baud_next;
        rem_reg    <= rem_next;
        quot_reg   <= quot_next;
        step_reg   <= step_next;
        div_reg    <= div_next;
        quanta_reg <= quanta_next;
        segs_reg   <= segs_next;
        qd_reg     <= qd_next;
        acc_reg    <= acc_next;
    end

    assign busy            = (state_reg != ST_IDLE);
    assign done            = done_reg;
    assign found           = found_reg;
    assign clock_divider   = cdiv_reg;
    assign bit_timing_word = word_reg;

endmodule

/* hdl/cbts_checker.sv */
// ----------------------------------------------------------------------------
// cbts_checker
// Port-level checks of the bit timing search core.
// ----------------------------------------------------------------------------
module cbts_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            start,
    input logic [cbts_pkg::BAUD_W-1:0]     bit_rate,
    input logic                            busy,
    input logic                            done,
    input logic                            found,
    input logic [cbts_pkg::DIV_W-1:0]      clock_divider,
    input logic [cbts_pkg::WORD_W-1:0]     bit_timing_word
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted word");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (clock_divider == '0 && bit_timing_word == '0))
        else $error("fields not cleared on miss");

    a_zero_baud: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && bit_rate == '0) |=> ##1 (done && !found))
        else $error("zero bit rate not answered as miss");

endmodule

bind can_bit_timing_search_core cbts_checker u_cbts_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .bit_rate        (bit_rate),
    .busy            (busy),
    .done            (done),
    .found           (found),
    .clock_divider   (clock_divider),
    .bit_timing_word (bit_timing_word)
);
